/* sv/time_ordered_event_queue_core_defines.svh */
// assertion helpers shared by the event queue rtl
`ifndef TIME_ORDERED_EVENT_QUEUE_CORE_DEFINES_SVH
`define TIME_ORDERED_EVENT_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TOEQ_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TOEQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/toeq_pkg.sv */
`timescale 1ns / 1ps

package toeq_pkg;

  // fixed field widths of the ports
  localparam int REQ_W  = 2;
  localparam int PID_W  = 16;
  localparam int EVT_W  = 32;
  localparam int STC_W  = 8;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  // default sizing
  localparam int CAPACITY_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int ID_BITS_DEF   = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic app;
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

/* sv/time_ordered_event_queue_core.sv */
`timescale 1ns / 1ps

// Time-ordered event queue built as a row of CAPACITY cells, one entry per cell,
// held in list order from the head at cell 0. Append writes the cell at the fill
// level, ordered insert writes the first cell whose time is strictly later (so
// equal times keep arrival order) while every cell behind it takes its left
// neighbor, and pop moves every cell one place toward the head. For each word the
// request is first registered; then, in the shift cycle, all cells compare
// their time with the new key and shift together; the next word is taken in the
// cycle after that. The result sits in an output register, so a new word can be
// taken while the previous result waits, but the shift cycle holds until the
// output register is free. Entries need no clearing after reset; only the
// occupied cells are ever read.

`include "time_ordered_event_queue_core_defines.svh"

module time_ordered_event_queue_core #(
  parameter int CAPACITY  = toeq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = toeq_pkg::TIME_BITS_DEF,
  parameter int ID_BITS   = toeq_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [toeq_pkg::REQ_W-1:0]    in_req_type,
  input  logic [toeq_pkg::PID_W-1:0]    in_proc_id,
  input  logic [toeq_pkg::EVT_W-1:0]    in_event_time,
  input  logic [toeq_pkg::STC_W-1:0]    in_state_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [toeq_pkg::PID_W-1:0]    out_proc_id,
  output logic [toeq_pkg::STC_W-1:0]    out_state_code,
  output logic [toeq_pkg::STAT_W-1:0]   out_status,
  output logic [toeq_pkg::FILL_W-1:0]   out_fill_count
);
  import toeq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = ID_BITS + TIME_BITS + STC_W;

  // request and control registers
  logic               busy_r,  busy_nxt;
  logic [REQ_W-1:0]   req_r;
  logic [ENT_W-1:0]   new_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               done;
  logic               full;
  logic               empty;
  cell_ctl_t          ctl;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [PID_W-1:0]   pid_r,  pid_nxt;
  logic [STC_W-1:0]   stc_r,  stc_nxt;
  logic [STAT_W-1:0]  stat_r, stat_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;

  // cell row wiring
  logic [ENT_W-1:0]   ent_w [CAPACITY];
  logic [CAPACITY:0]  found_w;
  logic [ENT_W-1:0]   head_ent;

  assign in_ready = !busy_r;

  // take the request word, trimmed to the stored widths
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req_type;
      new_r <= {ID_BITS'(in_proc_id), TIME_BITS'(in_event_time), in_state_code};
    end
  end

  // shift cycle runs once the output register can take the result
  assign done  = busy_r && (!out_valid_r || out_ready);
  assign full  = count_r == CNT_W'(CAPACITY);
  assign empty = count_r == '0;

  always_comb begin
    ctl.app = done && (req_r == REQ_APPEND) && !full;
    ctl.ins = done && (req_r == REQ_INSERT) && !full;
    ctl.pop = done && (req_r == REQ_POP) && !empty;
  end

  // fill level
  always_comb begin
    count_nxt = count_r;
    if (ctl.app || ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // cell row
  assign found_w[0] = 1'b0;
  assign head_ent   = ent_w[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENT_W-1:0] left_ent;
    logic [ENT_W-1:0] right_ent;

    if (i == 0) begin : g_first
      assign left_ent = new_r;
    end else begin : g_mid_l
      assign left_ent = ent_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = ent_w[i];
    end else begin : g_mid_r
      assign right_ent = ent_w[i+1];
    end

    toeq_cell #(
      .TIME_BITS (TIME_BITS),
      .ID_BITS   (ID_BITS),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .new_ent   (new_r),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .found_in  (found_w[i]),
      .found_out (found_w[i+1]),
      .ent_q     (ent_w[i])
    );
  end

  // result word
  always_comb begin
    pid_nxt  = pid_r;
    stc_nxt  = stc_r;
    stat_nxt = stat_r;
    fill_nxt = fill_r;
    if (done) begin
      pid_nxt  = '0;
      stc_nxt  = '0;
      stat_nxt = ST_OK;
      fill_nxt = FILL_W'(count_nxt);
      if ((req_r == REQ_APPEND || req_r == REQ_INSERT) && full) begin
        stat_nxt = ST_FULL;
      end else if (req_r == REQ_POP && empty) begin
        stat_nxt = ST_EMPTY;
      end else if (req_r == REQ_POP) begin
        pid_nxt = PID_W'(head_ent[ENT_W-1:TIME_BITS+STC_W]);
        stc_nxt = head_ent[STC_W-1:0];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_valid && in_ready) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = done || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_r  <= pid_nxt;
    stc_r  <= stc_nxt;
    stat_r <= stat_nxt;
    fill_r <= fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_proc_id    = pid_r;
  assign out_state_code = stc_r;
  assign out_status     = stat_r;
  assign out_fill_count = fill_r;

  // checks
  `TOEQ_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, busy_r, "accepted word did not start a shift cycle")
  `TOEQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "fill level above capacity")
  `TOEQ_ASSERT_NEXT(a_count_hold, !done, $stable(count_r), "fill level moved outside a shift cycle")
  `TOEQ_ASSERT_NOW(a_full_status, out_valid_r && stat_r == ST_FULL, count_r == CNT_W'(CAPACITY), "full status with room left")
  `TOEQ_ASSERT_NOW(a_empty_status, out_valid_r && stat_r == ST_EMPTY, count_r == '0, "empty status with entries held")

endmodule

/* sv/toeq_cell.sv */
`timescale 1ns / 1ps

module toeq_cell #(
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 16,
  parameter int CNT_W     = 5,
  parameter int IDX       = 0
) (
  input  logic                                      clk,
  input  toeq_pkg::cell_ctl_t                       ctl,
  input  logic [CNT_W-1:0]                          count,
  input  logic [ID_BITS+TIME_BITS+toeq_pkg::STC_W-1:0] new_ent,
  input  logic [ID_BITS+TIME_BITS+toeq_pkg::STC_W-1:0] left_ent,
  input  logic [ID_BITS+TIME_BITS+toeq_pkg::STC_W-1:0] right_ent,
  input  logic                                      found_in,
  output logic                                      found_out,
  output logic [ID_BITS+TIME_BITS+toeq_pkg::STC_W-1:0] ent_q
);
  import toeq_pkg::*;

  localparam int ENT_W = ID_BITS + TIME_BITS + STC_W;

  logic [ENT_W-1:0]     ent_r;
  logic [ENT_W-1:0]     ent_nxt;
  logic [TIME_BITS-1:0] own_time;
  logic [TIME_BITS-1:0] new_time;
  logic                 occupied;
  logic                 is_tail;
  logic                 hit;

  // slot position against the fill level
  assign occupied = CNT_W'(IDX) < count;
  assign is_tail  = CNT_W'(IDX) == count;

  // strictly later entry marks the insert point
  assign own_time  = ent_r[TIME_BITS+STC_W-1:STC_W];
  assign new_time  = new_ent[TIME_BITS+STC_W-1:STC_W];
  assign hit       = occupied && (own_time > new_time);
  assign found_out = found_in | hit;

  // next entry: keep, shift from a neighbor or take the new word
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.pop) begin
      ent_nxt = right_ent;
    end else if (ctl.app) begin
      if (is_tail) begin
        ent_nxt = new_ent;
      end
    end else if (ctl.ins) begin
      if (found_in) begin
        ent_nxt = left_ent;
      end else if (hit || is_tail) begin
        ent_nxt = new_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_q = ent_r;

endmodule

/* verif/toeq_checker.sv */
`timescale 1ns / 1ps

module toeq_checker
  import toeq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [PID_W-1:0]  in_proc_id,
  input  logic [EVT_W-1:0]  in_event_time,
  input  logic [STC_W-1:0]  in_state_code,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [PID_W-1:0]  out_proc_id,
  input  logic [STC_W-1:0]  out_state_code,
  input  logic [STAT_W-1:0] out_status,
  input  logic [FILL_W-1:0] out_fill_count,
  output int                fail_count,
  output int                awaited_count,
  output int                words_in,
  output int                words_out,
  output int                full_rejects,
  output int                empty_pops
);

  localparam int DEPTH = CAPACITY_DEF;

  // one expected result word
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [STC_W-1:0]  code;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill;
  } queue_result_t;

  // shadow copy of the event list, head at index 0
  logic [PID_W-1:0] held_pid  [DEPTH];
  logic [EVT_W-1:0] held_time [DEPTH];
  logic [STC_W-1:0] held_code [DEPTH];
  int               held_count;

  queue_result_t awaited_results [$];

  task automatic report_mismatch(input string what);
    if (fail_count < 40) $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  // apply one request to the shadow list and queue the word it must produce
  task automatic predict_request(input logic [REQ_W-1:0] req, input logic [PID_W-1:0] pid,
                                 input logic [EVT_W-1:0] t, input logic [STC_W-1:0] code);
    queue_result_t res;
    int pos;
    res = '0;
    if (req == REQ_APPEND || req == REQ_INSERT) begin
      if (held_count >= DEPTH) begin
        res.status = ST_FULL;
        full_rejects++;
      end else begin
        pos = held_count;
        if (req == REQ_INSERT) begin
          // land after every entry with an equal or earlier time
          pos = 0;
          while (pos < held_count && held_time[pos] <= t) pos++;
          for (int k = held_count; k > pos; k--) begin
            held_pid[k]  = held_pid[k-1];
            held_time[k] = held_time[k-1];
            held_code[k] = held_code[k-1];
          end
        end
        held_pid[pos]  = pid;
        held_time[pos] = t;
        held_code[pos] = code;
        held_count++;
        res.status = ST_OK;
      end
    end else if (req == REQ_POP) begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
        empty_pops++;
      end else begin
        res.pid  = held_pid[0];
        res.code = held_code[0];
        for (int k = 1; k < held_count; k++) begin
          held_pid[k-1]  = held_pid[k];
          held_time[k-1] = held_time[k];
          held_code[k-1] = held_code[k];
        end
        held_count--;
        res.status = ST_OK;
      end
    end else begin
      // unused request code leaves the list alone
      res.status = ST_OK;
    end
    res.fill = FILL_W'(held_count);
    awaited_results.push_back(res);
  endtask

  // watch both channels; inputs are taken before results
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      held_count = 0;
      awaited_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        words_in++;
        predict_request(in_req_type, in_proc_id, in_event_time, in_state_code);
      end
      if (out_valid && out_ready) begin
        words_out++;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending (status %0d)",
                                    out_status));
        end else begin
          want = awaited_results.pop_front();
          if (out_proc_id !== want.pid)
            report_mismatch($sformatf("proc_id got 0x%0h want 0x%0h", out_proc_id, want.pid));
          if (out_state_code !== want.code)
            report_mismatch($sformatf("state_code got 0x%0h want 0x%0h",
                                      out_state_code, want.code));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_fill_count !== want.fill)
            report_mismatch($sformatf("fill_count got %0d want %0d",
                                      out_fill_count, want.fill));
        end
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import toeq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1250;
  localparam int CALM_WORDS   = 150;
  localparam int CYCLE_LIMIT  = 400_000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type;
  logic [PID_W-1:0]  in_proc_id;
  logic [EVT_W-1:0]  in_event_time;
  logic [STC_W-1:0]  in_state_code;
  logic              out_valid;
  logic              out_ready;
  logic [PID_W-1:0]  out_proc_id;
  logic [STC_W-1:0]  out_state_code;
  logic [STAT_W-1:0] out_status;
  logic [FILL_W-1:0] out_fill_count;

  int fail_count;
  int awaited_count;
  int words_in;
  int words_out;
  int full_rejects;
  int empty_pops;
  int cycle_count;
  bit calm_tail;

  time_ordered_event_queue_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_proc_id     (in_proc_id),
    .in_event_time  (in_event_time),
    .in_state_code  (in_state_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_proc_id    (out_proc_id),
    .out_state_code (out_state_code),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  toeq_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_proc_id     (in_proc_id),
    .in_event_time  (in_event_time),
    .in_state_code  (in_state_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_proc_id    (out_proc_id),
    .out_state_code (out_state_code),
    .out_status     (out_status),
    .out_fill_count (out_fill_count),
    .fail_count     (fail_count),
    .awaited_count  (awaited_count),
    .words_in       (words_in),
    .words_out      (words_out),
    .full_rejects   (full_rejects),
    .empty_pops     (empty_pops)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               awaited_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side back-pressure in bursts, off in the calm tail
  initial begin : out_stall_gen
    int run;
    out_ready <= 1'b1;
    forever begin
      run = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
      repeat (run) @(posedge clk);
      if (!calm_tail && $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // present one word after an optional gap, return at the edge it is taken
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [PID_W-1:0] pid,
                           input logic [EVT_W-1:0] t, input logic [STC_W-1:0] code,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_proc_id    <= pid;
    in_event_time <= t;
    in_state_code <= code;
    do @(posedge clk); while (!in_ready);
  endtask

  // time keys crowd into small ranges so ties and sign-bit neighbors come up often
  function automatic logic [EVT_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return EVT_W'($urandom_range(0, 7));
      5, 6:          return $urandom;
      7, 8:          return 32'h7FFF_FFFE + EVT_W'($urandom_range(0, 3));
      default:       return 32'hFFFF_FFFF - EVT_W'($urandom_range(0, 2));
    endcase
  endfunction

  // random word biased by segment mode: 0 fills, 1 drains, 2 mixes
  task automatic send_random(input int mode, input int idle_style);
    logic [REQ_W-1:0] req;
    int push_pct;
    int gap;
    push_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 52;
    if ($urandom_range(0, 99) < 3)
      req = REQ_UNUSED;
    else if ($urandom_range(0, 99) < push_pct)
      req = ($urandom_range(0, 9) < 6) ? REQ_INSERT : REQ_APPEND;
    else
      req = REQ_POP;
    gap = 0;
    if (!calm_tail && idle_style != 0 &&
        $urandom_range(0, (idle_style == 1) ? 7 : 2) == 0)
      gap = $urandom_range(1, 19);
    send_word(req, PID_W'($urandom), pick_time(), STC_W'($urandom), gap);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int sent;
    int seg_len;
    int mode;
    int idle_style;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_APPEND;
    in_proc_id    <= '0;
    in_event_time <= '0;
    in_state_code <= '0;
    calm_tail = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: pop and the unused code
    send_word(REQ_POP, 16'h1234, 32'h0000_0010, 8'h5A, 0);
    send_word(REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 0);
    // extremes of every field, ties on both ends of the time range
    send_word(REQ_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 0);
    send_word(REQ_INSERT, 16'h0000, 32'h0000_0000, 8'h00, 0);
    send_word(REQ_INSERT, 16'h0001, 32'hFFFF_FFFF, 8'h01, 2);
    send_word(REQ_INSERT, 16'h0002, 32'h0000_0000, 8'h02, 0);
    // unsigned compare across the sign bit
    send_word(REQ_INSERT, 16'h8000, 32'h8000_0000, 8'h80, 0);
    send_word(REQ_INSERT, 16'h7FFF, 32'h7FFF_FFFF, 8'h7F, 0);
    // append ignores time
    send_word(REQ_APPEND, 16'h0005, 32'h0000_0005, 8'h05, 0);
    send_word(REQ_UNUSED, 16'hA5A5, 32'h1234_5678, 8'hA5, 0);
    // fill to capacity
    for (int i = 0; i < 9; i++)
      send_word((i % 2) ? REQ_APPEND : REQ_INSERT, 16'h5A5A ^ PID_W'(i),
                32'h0000_0100 + EVT_W'(i % 3), 8'hC3 ^ STC_W'(i), 0);
    // both kinds of push on a full list
    send_word(REQ_APPEND, 16'hDEAD, 32'h0000_0001, 8'hEE, 0);
    send_word(REQ_INSERT, 16'hBEEF, 32'h0000_0000, 8'hDD, 0);
    send_word(REQ_UNUSED, 16'h0000, 32'h0000_0000, 8'h00, 0);
    repeat (3) send_word(REQ_POP, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 0);

    // random segments with their own request mix and idling style
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      seg_len    = $urandom_range(10, 60);
      mode       = $urandom_range(0, 2);
      idle_style = $urandom_range(0, 2);
      for (int i = 0; i < seg_len && sent < RANDOM_WORDS; i++) begin
        if (sent >= RANDOM_WORDS - CALM_WORDS) calm_tail = 1'b1;
        send_random(mode, idle_style);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // drain what is still in flight
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests and %0d results in %0d cycles", words_in, words_out,
             cycle_count);
    $display("%0d pushes rejected on a full list, %0d pops on an empty list",
             full_rejects, empty_pops);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
